[sv/assert_macros.svh]
// Assertion helper macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// Check that the consequent holds whenever the antecedent holds.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

[sv/nsc_pkg.sv]
// ============================================================================
// NMEA sentence checker package
// Shared types, character codes and a helper function.
// ============================================================================
`default_nettype none

package nsc_pkg;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_0      = 8'd48;
   localparam logic [7:0] CHAR_9      = 8'd57;
   localparam logic [7:0] CHAR_A      = 8'd65;
   localparam logic [7:0] CHAR_F      = 8'd70;
   localparam logic [7:0] HEX_A_BIAS  = 8'd55;

   localparam int unsigned HDR_LEN   = 5;
   localparam int unsigned HDR_COUNT = 3;

   localparam logic [2:0] POS_HDR_END = 3'd5;
   localparam logic [2:0] POS_KIND    = 3'd6;
   localparam logic [2:0] POS_MAX     = 3'd7;

   // Header names, character 0 at index 0
   localparam logic [HDR_COUNT-1:0][HDR_LEN-1:0][7:0] HDR_NAMES = '{
      '{"1", "C", "R", "C", "O"},   // OCRC1
      '{"C", "M", "R", "P", "G"},   // GPRMC
      '{"A", "G", "G", "P", "G"}    // GPGGA
   };

   typedef enum logic [1:0] {
      KIND_OTHER = 2'd0,
      KIND_GPGGA = 2'd1,
      KIND_GPRMC = 2'd2,
      KIND_OCRC1 = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_BODY = 2'd1,
      PH_HEX1 = 2'd2,
      PH_HEX2 = 2'd3
   } phase_type;

   typedef struct packed {
      logic       sentence_ok;
      kind_type   sentence_kind;
      logic [7:0] computed_sum;
      logic [7:0] received_sum;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type result;
   } push_type;

   typedef struct packed {
      logic main_full;
      logic skid_full;
   } buf_status_type;

   // Upper-case hex digit value; anything else reads as zero
   function automatic logic [3:0] digit_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= CHAR_A && c <= CHAR_F) begin
         v = c - HEX_A_BIAS;
      end else if (c >= CHAR_0 && c <= CHAR_9) begin
         v = c - CHAR_0;
      end
      return v[3:0];
   endfunction

endpackage

`default_nettype wire

[sv/nmea_sentence_checker.sv]
// ============================================================================
// NMEA sentence checker
// Streaming checksum verifier and header classifier for NMEA 0183 text.
// ============================================================================
// Feed one character per transfer on req_. The block ignores everything until
// a '$', then XORs each body byte into a running sum until '*' (a '*' among
// the first five body bytes is treated as data). The five header characters
// plus a following comma are matched against GPGGA, GPRMC and OCRC1. After
// '*' two upper-case hex digits are read; any other character in a digit
// slot counts as zero. One result transfer appears on rsp_ after the second
// digit, or at CR/LF if the sentence is still open (no '*' means
// sentence_ok is 0 and received_sum is 0). Throughput is one character per
// clock while req_stall is low: each byte is held in the input register,
// the sentence state updates while it sits there and any result is written
// into the output register, which drives rsp_valid. An output register with
// one skid entry lets new characters flow while a result waits; req_stall
// rises only when both are full and a byte is still pending.
`default_nettype none

module nmea_sentence_checker import nsc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_sentence_ok,
   output logic [1:0]      rsp_sentence_kind,
   output logic [7:0]      rsp_computed_sum,
   output logic [7:0]      rsp_received_sum
);

   `include "assert_macros.svh"

   push_type       push;
   buf_status_type buf_status;
   result_type     rsp_result;

   // Parse each byte and form the result
   nsc_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_stall   (req_stall),
      .buf_status  (buf_status),
      .push        (push)
   );

   // Hold results until the downstream transfer completes
   nsc_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .buf_status (buf_status),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_sentence_ok   = rsp_result.sentence_ok;
   assign rsp_sentence_kind = rsp_result.sentence_kind;
   assign rsp_computed_sum  = rsp_result.computed_sum;
   assign rsp_received_sum  = rsp_result.received_sum;

   // The skid entry fills only behind a full output register
   `ASSERT_IMPLIES(a_skid_behind_main, clock, reset, buf_status.skid_full, buf_status.main_full, "skid entry valid with empty output register")
   // Never push a result into a full buffer
   `ASSERT_IMPLIES(a_no_overflow, clock, reset, push.valid, !buf_status.skid_full, "result pushed into full buffer")
   // Input stalls only while a result is waiting
   `ASSERT_IMPLIES(a_stall_has_cause, clock, reset, req_stall, rsp_valid, "input stalled with empty output")
   // Reset empties the output
   `ASSERT_IMPLIES(a_reset_clears, clock, 1'b0, ($past(reset) && !reset), !rsp_valid, "result valid right after reset")

endmodule

`default_nettype wire

[sv/nsc_parser.sv]
// ============================================================================
// NMEA sentence parser stage
// Input register plus per-byte sentence state update and result formation.
// ============================================================================
`default_nettype none

module nsc_parser import nsc_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic [7:0]     req_in_byte,
   output logic                req_stall,
   input  wire buf_status_type buf_status,
   output push_type            push
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       advance;
   logic       take;

   phase_type  phase_ff, phase_in;
   logic [2:0] pos_ff, pos_in;
   logic [7:0] xor_ff, xor_in;
   logic [2:0] match_ff, match_in;
   logic [7:0] hex_ff, hex_in;

   logic       eol;
   logic [7:0] rx;
   kind_type   kind_now;

   // Hold the byte while the result buffer has no room
   assign advance   = in_valid_ff && !buf_status.skid_full;
   assign req_stall = in_valid_ff && buf_status.skid_full;
   assign take      = req_valid && !req_stall;
   assign in_valid_in = take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= 3'd0;
         xor_ff   <= 8'd0;
         match_ff <= '1;
         hex_ff   <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         xor_ff   <= xor_in;
         match_ff <= match_in;
         hex_ff   <= hex_in;
      end
   end

   assign eol = (in_byte_ff == CHAR_CR) || (in_byte_ff == CHAR_LF);

   always_comb begin
      kind_now = KIND_OTHER;
      if (pos_ff >= POS_KIND) begin
         if (match_ff[0]) begin
            kind_now = KIND_GPGGA;
         end else if (match_ff[1]) begin
            kind_now = KIND_GPRMC;
         end else if (match_ff[2]) begin
            kind_now = KIND_OCRC1;
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      xor_in   = xor_ff;
      match_in = match_ff;
      hex_in   = hex_ff;
      rx       = 8'd0;
      push.valid                = 1'b0;
      push.result.sentence_ok   = 1'b0;
      push.result.sentence_kind = kind_now;
      push.result.computed_sum  = xor_ff;
      push.result.received_sum  = 8'd0;
      if (advance) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (in_byte_ff == CHAR_DOLLAR) begin
                  phase_in = PH_BODY;
                  pos_in   = 3'd0;
                  xor_in   = 8'd0;
                  match_in = '1;
                  hex_in   = 8'd0;
               end
            end
            PH_BODY: begin
               if (eol) begin
                  // no star: report as invalid
                  push.valid = 1'b1;
                  phase_in   = PH_IDLE;
               end else if (in_byte_ff == CHAR_STAR && pos_ff >= POS_HDR_END) begin
                  phase_in = PH_HEX1;
               end else begin
                  xor_in = xor_ff ^ in_byte_ff;
                  if (pos_ff < POS_HDR_END) begin
                     for (int k = 0; k < HDR_COUNT; k++) begin
                        if (HDR_NAMES[k][pos_ff] != in_byte_ff) begin
                           match_in[k] = 1'b0;
                        end
                     end
                  end else if (pos_ff == POS_HDR_END && in_byte_ff != CHAR_COMMA) begin
                     match_in = '0;
                  end
                  if (pos_ff < POS_MAX) begin
                     pos_in = pos_ff + 3'd1;
                  end
               end
            end
            PH_HEX1: begin
               if (eol) begin
                  push.valid              = 1'b1;
                  push.result.sentence_ok = (xor_ff == 8'd0);
                  phase_in                = PH_IDLE;
               end else begin
                  hex_in   = {digit_value(in_byte_ff), 4'd0};
                  phase_in = PH_HEX2;
               end
            end
            PH_HEX2: begin
               rx = eol ? hex_ff : (hex_ff | {4'd0, digit_value(in_byte_ff)});
               push.valid               = 1'b1;
               push.result.sentence_ok  = (xor_ff == rx);
               push.result.received_sum = rx;
               phase_in                 = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[sv/nsc_out_buf.sv]
// ============================================================================
// NMEA sentence checker result buffer
// Output register with one skid entry behind it.
// ============================================================================
`default_nettype none

module nsc_out_buf import nsc_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output buf_status_type buf_status,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output result_type    rsp_result
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop = main_valid_ff && !rsp_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // no push arrives while the skid is full
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push.valid) begin
         if (!main_valid_ff || pop) begin
            main_in       = push.result;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push.result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign buf_status.main_full = main_valid_ff;
   assign buf_status.skid_full = skid_valid_ff;
   assign rsp_valid  = main_valid_ff;
   assign rsp_result = main_ff;

endmodule

`default_nettype wire
